// ===== rtl/core/gecd_pkg.sv =====
// ----------------------------------------------------------------------------
// gecd_pkg
// Shared constants, controller states and the command/status words that
// join the controller and the datapath of the grid edge cycle detector.
// ----------------------------------------------------------------------------
package gecd_pkg;

  localparam int COORD_W      = 9;
  localparam int COUNT_W      = 18;
  localparam int MAX_SIDE_DEF = 256;

  localparam logic [COORD_W-1:0] SIDE_RESET = 9'd256;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 18'h3FFFF;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_DECIDE,
    ST_FIND_ISS,
    ST_FIND,
    ST_COMP_ISS,
    ST_COMP,
    ST_LINK,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic calc;
    logic calc_b;
    logic count_inc;
    logic start_walk;
    logic step_walk;
    logic comp_start;
    logic comp_step;
    logic link;
    logic res_load;
    logic phase;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic skip;
    logic parent_is_root;
    logic cell_is_root;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/core/gecd_edge_if.sv =====
// ----------------------------------------------------------------------------
// gecd_edge_if
// Edge word channel: start cell (row, col) and direction.
// ----------------------------------------------------------------------------
interface gecd_edge_if;

  logic                         valid;
  logic                         ready;
  logic [gecd_pkg::COORD_W-1:0] row;
  logic [gecd_pkg::COORD_W-1:0] col;
  logic                         mode;

  modport source (output valid, output row, output col, output mode, input ready);
  modport sink   (input valid, input row, input col, input mode, output ready);

endinterface

// ===== rtl/core/gecd_result_if.sv =====
// ----------------------------------------------------------------------------
// gecd_result_if
// Result word channel: loop flags, move number and bad edge flag.
// ----------------------------------------------------------------------------
interface gecd_result_if;

  logic                         valid;
  logic                         ready;
  logic                         closes_loop;
  logic                         done_res;
  logic [gecd_pkg::COUNT_W-1:0] move_number;
  logic                         bad_edge;

  modport source (output valid, output closes_loop, output done_res,
                  output move_number, output bad_edge, input ready);
  modport sink   (input valid, input closes_loop, input done_res,
                  input move_number, input bad_edge, output ready);

endinterface

// ===== rtl/core/gecd_ram.sv =====
// ----------------------------------------------------------------------------
// gecd_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gecd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/gecd_ctrl.sv =====
// ----------------------------------------------------------------------------
// gecd_ctrl
// Controller: clears parent memory after reset; each edge gets a result after
// cell calculation and, unless skipped, two compressing root walks and a link.
// ----------------------------------------------------------------------------
module gecd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gecd_pkg::sts_t sts_i,
  output gecd_pkg::cmd_t cmd_o
);

  import gecd_pkg::*;

  state_e state_q, state_d;
  logic   phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    cmd_o      = '0;
    cmd_o.phase = phase_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.calc_b = 1'b1;
        if (sts_i.skip) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.count_inc = 1'b1;
          phase_d         = 1'b0;
          state_d         = ST_FIND_ISS;
        end
      end
      ST_FIND_ISS: begin
        cmd_o.start_walk = 1'b1;
        state_d          = ST_FIND;
      end
      ST_FIND: begin
        if (sts_i.parent_is_root) begin
          state_d = ST_COMP_ISS;
        end else begin
          cmd_o.step_walk = 1'b1;
        end
      end
      ST_COMP_ISS: begin
        cmd_o.comp_start = 1'b1;
        if (sts_i.cell_is_root) begin
          if (!phase_q) begin
            phase_d = 1'b1;
            state_d = ST_FIND_ISS;
          end else begin
            state_d = ST_LINK;
          end
        end else begin
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        cmd_o.comp_step = 1'b1;
        if (sts_i.parent_is_root) begin
          if (!phase_q) begin
            phase_d = 1'b1;
            state_d = ST_FIND_ISS;
          end else begin
            state_d = ST_LINK;
          end
        end
      end
      ST_LINK: begin
        cmd_o.link = 1'b1;
        state_d    = ST_OUT;
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== rtl/core/gecd_datapath.sv =====
// ----------------------------------------------------------------------------
// gecd_datapath
// Datapath: side register, cell numbering, parent memory with walk and
// compression pointers, edge counter, loop flag and result register.
// ----------------------------------------------------------------------------
module gecd_datapath #(
  parameter int MAX_SIDE = gecd_pkg::MAX_SIDE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gecd_pkg::cmd_t               cmd_i,
  output gecd_pkg::sts_t               sts_o,
  input  logic                         cfg_we_i,
  input  logic [gecd_pkg::COORD_W-1:0] cfg_wdata_i,
  input  logic [gecd_pkg::COORD_W-1:0] row_i,
  input  logic [gecd_pkg::COORD_W-1:0] col_i,
  input  logic                         mode_i,
  input  logic                         res_ready_i,
  output logic                         res_valid_o,
  output logic                         closes_loop_o,
  output logic                         done_res_o,
  output logic [gecd_pkg::COUNT_W-1:0] move_number_o,
  output logic                         bad_edge_o
);

  import gecd_pkg::*;

  localparam int CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int CELL_W = $clog2(CELLS);
  localparam int PROD_W = 2 * COORD_W;

  logic [COORD_W-1:0] side_cfg_q;
  logic [COORD_W-1:0] side_eff;
  logic [COORD_W-1:0] side_q, row_q, col_q;
  logic               down_q;
  logic               bad_q, bad_d;
  logic [CELL_W-1:0]  cell_a_q, cell_b_q, cell_sel;
  logic [CELL_W-1:0]  walk_q, cur_q, root_a_q, clr_q;
  logic [PROD_W-1:0]  prod, sum;
  logic [COUNT_W-1:0] count_q;
  logic               loop_found_q, closes_q;
  logic               res_valid_q;
  logic               res_closes_q, res_done_q, res_bad_q;
  logic [COUNT_W-1:0] res_move_q;
  logic               roots_equal;
  logic               mem_we;
  logic [CELL_W-1:0]  mem_waddr, mem_wdata, mem_raddr, mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_cfg_q <= SIDE_RESET;
    end else if (cfg_we_i) begin
      side_cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (side_cfg_q == '0) begin
      side_eff = COORD_W'(1);
    end else if (32'(side_cfg_q) > MAX_SIDE) begin
      side_eff = COORD_W'(MAX_SIDE);
    end else begin
      side_eff = side_cfg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q  <= row_i;
      col_q  <= col_i;
      down_q <= mode_i;
      side_q <= side_eff;
    end
  end

  assign bad_d = (row_q == '0) || (row_q > side_q) || (col_q == '0) || (col_q > side_q) ||
                 (down_q && (row_q == side_q)) || (!down_q && (col_q == side_q));
  assign prod  = PROD_W'(row_q - COORD_W'(1)) * PROD_W'(side_q);
  assign sum   = prod + PROD_W'(col_q - COORD_W'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      cell_a_q <= CELL_W'(sum);
      bad_q    <= bad_d;
    end
    if (cmd_i.calc_b) begin
      cell_b_q <= cell_a_q + (down_q ? CELL_W'(side_q) : CELL_W'(1));
    end
  end

  assign cell_sel    = cmd_i.phase ? cell_b_q : cell_a_q;
  assign roots_equal = (root_a_q == walk_q);

  // walk pointer ends on the root; cur runs the compression pass
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_walk) begin
      walk_q <= cell_sel;
    end else if (cmd_i.step_walk) begin
      walk_q <= mem_rdata;
    end
    if (cmd_i.comp_start) begin
      cur_q <= cell_sel;
      if (!cmd_i.phase) begin
        root_a_q <= walk_q;
      end
    end else if (cmd_i.comp_step) begin
      cur_q <= mem_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      count_q      <= '0;
      loop_found_q <= 1'b0;
      closes_q     <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + CELL_W'(1);
      end
      if (cmd_i.count_inc && (count_q != COUNT_MAX)) begin
        count_q <= count_q + COUNT_W'(1);
      end
      if (cmd_i.calc) begin
        closes_q <= 1'b0;
      end else if (cmd_i.link && roots_equal) begin
        closes_q     <= 1'b1;
        loop_found_q <= 1'b1;
      end
      if (cmd_i.res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_closes_q <= closes_q;
      res_done_q   <= loop_found_q;
      res_bad_q    <= bad_q;
      res_move_q   <= (bad_q && !loop_found_q) ? '0 : count_q;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = clr_q;
    if (cmd_i.clr_step) begin
      mem_we = 1'b1;
    end else if (cmd_i.comp_step) begin
      mem_we    = 1'b1;
      mem_waddr = cur_q;
      mem_wdata = walk_q;
    end else if (cmd_i.link && !roots_equal) begin
      mem_we    = 1'b1;
      mem_waddr = root_a_q;
      mem_wdata = walk_q;
    end
  end

  assign mem_raddr = (cmd_i.step_walk || cmd_i.comp_step) ? mem_rdata : cell_sel;

  gecd_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign sts_o.clr_last       = (clr_q == CELL_W'(CELLS - 1));
  assign sts_o.skip           = bad_q || loop_found_q;
  assign sts_o.parent_is_root = (mem_rdata == walk_q);
  assign sts_o.cell_is_root   = (cell_sel == walk_q);
  assign sts_o.out_busy       = res_valid_q && !res_ready_i;

  assign res_valid_o   = res_valid_q;
  assign closes_loop_o = res_closes_q;
  assign done_res_o    = res_done_q;
  assign move_number_o = res_move_q;
  assign bad_edge_o    = res_bad_q;

endmodule

// ===== rtl/core/grid_edge_cycle_detector_unit.sv =====
// ----------------------------------------------------------------------------
// grid_edge_cycle_detector_unit
// Union-find loop detection over the cells of a square grid. Each edge word
// joins a cell to its right or lower neighbor; equal roots flag a loop.
// ----------------------------------------------------------------------------
// One edge word at a time. A valid edge walks each end cell's path to its
// root twice, once to find the root and once to compress the path, both
// through the single read port of the parent memory. A bad edge, or any
// edge after a loop was found, skips the walks and the link. After reset
// the parent memory is cleared to self-pointers, one entry per cycle, all
// MAX_SIDE*MAX_SIDE entries (65536 at the default), before the first edge
// is taken; grid_side writes are taken meanwhile. The result register lets
// the next edge enter while a result still waits.
// ----------------------------------------------------------------------------
module grid_edge_cycle_detector_unit #(
  parameter int MAX_SIDE = gecd_pkg::MAX_SIDE_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gecd_pkg::COORD_W-1:0] cfg_wdata_i,
  gecd_edge_if.sink                    edge_i,
  gecd_result_if.source                res_o
);

  import gecd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gecd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (edge_i.valid),
    .in_ready_o (edge_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gecd_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .row_i         (edge_i.row),
    .col_i         (edge_i.col),
    .mode_i        (edge_i.mode),
    .res_ready_i   (res_o.ready),
    .res_valid_o   (res_o.valid),
    .closes_loop_o (res_o.closes_loop),
    .done_res_o    (res_o.done_res),
    .move_number_o (res_o.move_number),
    .bad_edge_o    (res_o.bad_edge)
  );

endmodule
